// ===== rtl/two_button_press_repeat_fsm_macros.svh =====
// Assertion macros for the button press RTL.
`ifndef TWO_BUTTON_PRESS_REPEAT_FSM_MACROS_SVH
`define TWO_BUTTON_PRESS_REPEAT_FSM_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define BTNREP_ASSERT_SAME(label, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (expr)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define BTNREP_ASSERT_NEXT(label, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
		else $error(msg);

`endif

// ===== rtl/btnrep_pkg.sv =====
// Package with state codes, flag masks and shared types for the button press block.
`timescale 1ns / 1ps
`default_nettype none

package btnrep_pkg;

	// State codes
	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_ONE      = 3'd1;
	localparam logic [2:0] ST_ONE_LONG = 3'd2;
	localparam logic [2:0] ST_TWO      = 3'd3;
	localparam logic [2:0] ST_TWO_LONG = 3'd4;
	localparam logic [2:0] ST_BOTH     = 3'd5;

	// Event flag masks, bit i is output field i
	localparam logic [6:0] F_ONE_REL   = 7'h01;
	localparam logic [6:0] F_ONE_SHORT = 7'h02;
	localparam logic [6:0] F_ONE_REP   = 7'h04;
	localparam logic [6:0] F_TWO_REL   = 7'h08;
	localparam logic [6:0] F_TWO_SHORT = 7'h10;
	localparam logic [6:0] F_TWO_REP   = 7'h20;
	localparam logic [6:0] F_BOTH_REL  = 7'h40;

	// Register indexes and reset values
	localparam logic [1:0] REG_FIRST_INTERVAL  = 2'd0;
	localparam logic [1:0] REG_REPEAT_INTERVAL = 2'd1;
	localparam logic [7:0] FIRST_INTERVAL_RST  = 8'd5;
	localparam logic [7:0] REPEAT_INTERVAL_RST = 8'd5;

	// Machine state carried from one tick to the next
	typedef struct packed {
		logic [2:0] state;
		logic [7:0] count;
		logic [6:0] flags;
	} press_ctx_t;

endpackage

`default_nettype wire

// ===== rtl/two_button_press_repeat_fsm.sv =====
// Top level of the two-button press, long-press and auto-repeat machine.
//
// Channel  Dir  Handshake           Payload
// s_*      in   s_tvalid/s_tready   s_tdata[2:0] = first, second pressed, flags_clear
// m_*      out  m_tvalid/m_tready   m_tdata[9:0] = seven event flags, machine_state
// cfg_*    in   cfg_valid/cfg_ready cfg_index selects interval, cfg_data value
//
// One tick per cycle sustained while the result is taken; each tick passes from the input
// transfer into the input register, then through the step logic into the result register.
// The result register alone gates throughput: input is taken whenever s1 is empty or drains.
// Reset clears state, counter, flags and handshake state and loads both intervals with 5.
// A stalled result holds the machine state; configuration is always taken.
`timescale 1ns / 1ps
`default_nettype none
`include "two_button_press_repeat_fsm_macros.svh"

module two_button_press_repeat_fsm (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        s_tvalid,
	output logic       s_tready,
	input  wire  [7:0] s_tdata,   // [0] first_pressed, [1] second_pressed, [2] flags_clear
	output logic       m_tvalid,
	input  wire        m_tready,
	output logic [15:0] m_tdata,  // [0] first_released, [1] first_short, [2] first_repeat,
	                              // [3] second_released, [4] second_short, [5] second_repeat,
	                              // [6] both_released, [9:7] machine_state
	input  wire        cfg_valid,
	output logic       cfg_ready,
	input  wire  [1:0] cfg_index,
	input  wire  [7:0] cfg_data
);

	logic                   valid_s1;
	logic                   first_s1;
	logic                   second_s1;
	logic                   clear_s1;
	logic                   advance;
	logic [7:0]             first_interval_q;
	logic [7:0]             repeat_interval_q;
	btnrep_pkg::press_ctx_t ctx_q;
	btnrep_pkg::press_ctx_t ctx_nxt;
	logic [9:0]             result_q;
	logic                   out_valid_q;

	assign advance   = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = {6'd0, result_q};

	// Write interval registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_interval_q  <= btnrep_pkg::FIRST_INTERVAL_RST;
			repeat_interval_q <= btnrep_pkg::REPEAT_INTERVAL_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				btnrep_pkg::REG_FIRST_INTERVAL:  first_interval_q  <= cfg_data;
				btnrep_pkg::REG_REPEAT_INTERVAL: repeat_interval_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input stage: capture a transfer, drop it once it advances
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			first_s1  <= s_tdata[0];
			second_s1 <= s_tdata[1];
			clear_s1  <= s_tdata[2];
		end
	end

	btnrep_step u_step (
		.cur             (ctx_q),
		.first_pressed   (first_s1),
		.second_pressed  (second_s1),
		.flags_clear     (clear_s1),
		.first_interval  (first_interval_q),
		.repeat_interval (repeat_interval_q),
		.nxt             (ctx_nxt)
	);

	// Machine state: advance once per tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_q.state <= btnrep_pkg::ST_IDLE;
			ctx_q.count <= 8'd0;
			ctx_q.flags <= 7'd0;
		end else if (advance) begin
			ctx_q <= ctx_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= {ctx_nxt.state, ctx_nxt.flags};
		end
	end

	`BTNREP_ASSERT_NEXT(a_result_after_advance, advance, out_valid_q, "no result after tick")
	`BTNREP_ASSERT_NEXT(a_stall_holds_state, !advance, $stable(ctx_q), "state moved while stalled")
	`BTNREP_ASSERT_SAME(a_result_matches_state, out_valid_q, result_q[9:7] == ctx_q.state,
		"shown state differs from machine state")
	`BTNREP_ASSERT_SAME(a_state_legal, 1'b1, ctx_q.state <= btnrep_pkg::ST_BOTH, "bad state code")

endmodule

`default_nettype wire

// ===== rtl/btnrep_step.sv =====
// Next-state logic for one sample tick of the button press machine.
`timescale 1ns / 1ps
`default_nettype none

module btnrep_step (
	input  wire btnrep_pkg::press_ctx_t cur,
	input  wire                         first_pressed,
	input  wire                         second_pressed,
	input  wire                         flags_clear,
	input  wire [7:0]                   first_interval,
	input  wire [7:0]                   repeat_interval,
	output btnrep_pkg::press_ctx_t      nxt
);

	logic [7:0] count_dec;

	assign count_dec = cur.count - 8'd1;

	// Advance the machine by one tick
	always_comb begin
		nxt.state = cur.state;
		nxt.count = cur.count;
		nxt.flags = flags_clear ? 7'd0 : cur.flags;
		unique case (cur.state)
			btnrep_pkg::ST_ONE: begin
				if (first_pressed) begin
					if (second_pressed) nxt.state = btnrep_pkg::ST_BOTH;
					nxt.count = count_dec;
					// long state wins over both held on expiry
					if (count_dec == 8'd0) begin
						nxt.state = btnrep_pkg::ST_ONE_LONG;
						nxt.count = repeat_interval;
					end
				end else begin
					nxt.flags = btnrep_pkg::F_ONE_REL | btnrep_pkg::F_ONE_SHORT;
					nxt.state = btnrep_pkg::ST_IDLE;
				end
			end
			btnrep_pkg::ST_ONE_LONG: begin
				if (first_pressed) begin
					if (second_pressed) nxt.state = btnrep_pkg::ST_BOTH;
					nxt.count = count_dec;
					if (count_dec == 8'd0) begin
						nxt.flags = nxt.flags | btnrep_pkg::F_ONE_REP;
						nxt.count = repeat_interval;
					end
				end else begin
					nxt.flags = btnrep_pkg::F_ONE_REL;
					nxt.state = btnrep_pkg::ST_IDLE;
				end
			end
			btnrep_pkg::ST_TWO: begin
				if (second_pressed) begin
					if (first_pressed) nxt.state = btnrep_pkg::ST_BOTH;
					nxt.count = count_dec;
					if (count_dec == 8'd0) begin
						nxt.state = btnrep_pkg::ST_TWO_LONG;
						nxt.count = repeat_interval;
					end
				end else begin
					nxt.flags = btnrep_pkg::F_TWO_REL | btnrep_pkg::F_TWO_SHORT;
					nxt.state = btnrep_pkg::ST_IDLE;
				end
			end
			btnrep_pkg::ST_TWO_LONG: begin
				if (second_pressed) begin
					if (first_pressed) nxt.state = btnrep_pkg::ST_BOTH;
					nxt.count = count_dec;
					if (count_dec == 8'd0) begin
						nxt.flags = nxt.flags | btnrep_pkg::F_TWO_REP;
						nxt.count = repeat_interval;
					end
				end else begin
					nxt.flags = btnrep_pkg::F_TWO_REL;
					nxt.state = btnrep_pkg::ST_IDLE;
				end
			end
			btnrep_pkg::ST_BOTH: begin
				// hold flags clear until both buttons are up
				nxt.flags = 7'd0;
				if (!first_pressed && !second_pressed) begin
					nxt.flags = btnrep_pkg::F_BOTH_REL;
					nxt.state = btnrep_pkg::ST_IDLE;
				end
			end
			default: begin
				// idle and unused codes: button two wins a tie
				nxt.state = btnrep_pkg::ST_IDLE;
				if (first_pressed) begin
					nxt.count = first_interval;
					nxt.state = btnrep_pkg::ST_ONE;
				end
				if (second_pressed) begin
					nxt.count = first_interval;
					nxt.state = btnrep_pkg::ST_TWO;
				end
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the two-button press, long-press and auto-repeat machine.
`timescale 1ns / 1ps

module tb_top;

	localparam int          CLK_HALF    = 2;
	localparam int          RESET_TICKS = 6;
	localparam int          CYCLE_LIMIT = 400000;
	localparam int          REPORT_MAX  = 10;
	localparam logic [1:0]  REG_SPARE_2 = 2'd2;
	localparam logic [1:0]  REG_SPARE_3 = 2'd3;

	// One observed tick: event flags and machine state
	typedef struct packed {
		logic [2:0] state;
		logic [6:0] flags;
	} tick_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;  // [0] first_pressed, [1] second_pressed, [2] flags_clear
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;       // [6:0] event flags, first_released up, [9:7] machine_state
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [7:0]  cfg_data = '0;

	// Predicted machine and its interval registers
	btnrep_pkg::press_ctx_t press_model;
	logic [7:0]             iv_first;
	logic [7:0]             iv_repeat;
	tick_result_t           expected_events[$];

	int mismatch_count = 0;
	int ticks_sent = 0;
	int cycle_count = 0;
	int tx_burst_left = 0;
	bit tx_gaps_on = 1'b1;
	bit rx_stall_on = 1'b1;
	int rx_phase = 0;
	int rx_period = 4;
	int rx_hold = 1;

	two_button_press_repeat_fsm u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #(CLK_HALF) clk = ~clk;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	// Receiver: when stalls are on, hold ready low at the start of each pattern period until the phase reaches rx_hold
	always @(posedge clk) begin
		if (!rx_stall_on) begin
			m_tready <= 1'b1;
		end else begin
			m_tready <= (rx_phase >= rx_hold);
			rx_phase++;
			if (rx_phase >= rx_period) begin
				rx_phase = 0;
				rx_period = $urandom_range(2, 16);
				rx_hold = $urandom_range(0, rx_period - 1);
			end
		end
	end

	task automatic note_failure(input string what);
		mismatch_count++;
		if (mismatch_count <= REPORT_MAX)
			$display("mismatch at cycle %0d: %s", cycle_count, what);
	endtask

	// Compare each result transfer with the oldest prediction
	always @(posedge clk) begin : check_results
		tick_result_t want;
		tick_result_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.flags = m_tdata[6:0];
			got.state = m_tdata[9:7];
			if (expected_events.size() == 0) begin
				note_failure($sformatf("result flags=%b state=%0d with no tick pending",
					got.flags, got.state));
			end else begin
				want = expected_events.pop_front();
				if (got.flags !== want.flags || got.state !== want.state)
					note_failure($sformatf("flags exp %b got %b, state exp %0d got %0d",
						want.flags, got.flags, want.state, got.state));
			end
		end
	end

	// Short-hold state of either button: count down, go long on expiry
	task automatic model_hold_short(input logic own, input logic other,
		input logic [2:0] long_state, input logic [6:0] release_flags);
		if (own) begin
			if (other)
				press_model.state = btnrep_pkg::ST_BOTH;
			press_model.count = press_model.count - 8'd1;
			if (press_model.count == 8'd0) begin
				press_model.state = long_state;
				press_model.count = iv_repeat;
			end
		end else begin
			press_model.flags = release_flags;
			press_model.state = btnrep_pkg::ST_IDLE;
		end
	endtask

	// Long-hold state of either button: raise repeat flag each interval
	task automatic model_hold_long(input logic own, input logic other,
		input logic [6:0] repeat_flag, input logic [6:0] release_flag);
		if (own) begin
			if (other)
				press_model.state = btnrep_pkg::ST_BOTH;
			press_model.count = press_model.count - 8'd1;
			if (press_model.count == 8'd0) begin
				press_model.flags = press_model.flags | repeat_flag;
				press_model.count = iv_repeat;
			end
		end else begin
			press_model.flags = release_flag;
			press_model.state = btnrep_pkg::ST_IDLE;
		end
	endtask

	// Advance the predicted machine by one tick and queue its result
	task automatic step_press_model(input logic b1, input logic b2, input logic clr);
		tick_result_t res;
		if (clr)
			press_model.flags = '0;
		case (press_model.state)
			btnrep_pkg::ST_ONE:
				model_hold_short(b1, b2, btnrep_pkg::ST_ONE_LONG,
					btnrep_pkg::F_ONE_REL | btnrep_pkg::F_ONE_SHORT);
			btnrep_pkg::ST_ONE_LONG:
				model_hold_long(b1, b2, btnrep_pkg::F_ONE_REP, btnrep_pkg::F_ONE_REL);
			btnrep_pkg::ST_TWO:
				model_hold_short(b2, b1, btnrep_pkg::ST_TWO_LONG,
					btnrep_pkg::F_TWO_REL | btnrep_pkg::F_TWO_SHORT);
			btnrep_pkg::ST_TWO_LONG:
				model_hold_long(b2, b1, btnrep_pkg::F_TWO_REP, btnrep_pkg::F_TWO_REL);
			btnrep_pkg::ST_BOTH: begin
				press_model.flags = '0;
				if (!b1 && !b2) begin
					press_model.flags = btnrep_pkg::F_BOTH_REL;
					press_model.state = btnrep_pkg::ST_IDLE;
				end
			end
			default: begin
				press_model.state = btnrep_pkg::ST_IDLE;
				if (b1) begin
					press_model.count = iv_first;
					press_model.state = btnrep_pkg::ST_ONE;
				end
				if (b2) begin
					press_model.count = iv_first;
					press_model.state = btnrep_pkg::ST_TWO;
				end
			end
		endcase
		res.flags = press_model.flags;
		res.state = press_model.state;
		expected_events.push_back(res);
	endtask

	// Send one tick, with a random gap whenever a burst runs out and gaps are on
	task automatic send_tick(input logic b1, input logic b2, input logic clr);
		int gap;
		if (tx_gaps_on && tx_burst_left == 0) begin
			gap = $urandom_range(1, 6);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
			tx_burst_left = $urandom_range(1, 24);
		end
		s_tdata <= {5'b0, clr, b2, b1};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		step_press_model(b1, b2, clr);
		if (tx_burst_left > 0)
			tx_burst_left--;
		ticks_sent++;
	endtask

	// Hold off input and wait until every predicted result has arrived
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (expected_events.size() != 0);
	endtask

	// Write one register; valid stays high until cfg_done
	task automatic cfg_write(input logic [1:0] idx, input logic [7:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			btnrep_pkg::REG_FIRST_INTERVAL:  iv_first = val;
			btnrep_pkg::REG_REPEAT_INTERVAL: iv_repeat = val;
			default: ;
		endcase
	endtask

	task automatic cfg_done();
		cfg_valid <= 1'b0;
	endtask

	task automatic set_intervals(input logic [7:0] first, input logic [7:0] rep);
		drain();
		cfg_write(btnrep_pkg::REG_FIRST_INTERVAL, first);
		cfg_write(btnrep_pkg::REG_REPEAT_INTERVAL, rep);
		cfg_done();
	endtask

	function automatic logic pulse_clear();
		return ($urandom_range(7) == 0);
	endfunction

	function automatic logic coin();
		return 1'($urandom_range(1));
	endfunction

	// Longest hold drawn: reaches the long state and a few repeats, capped at 40
	function automatic int hold_span();
		int span;
		span = int'(iv_first) + 2 * int'(iv_repeat) + 2;
		return (span > 40) ? 40 : span;
	endfunction

	// One random gesture: press and release, chord, simultaneous press or noise
	task automatic run_gesture();
		int pick;
		int hold;
		logic on_first;
		pick = $urandom_range(99);
		hold = $urandom_range(1, hold_span());
		on_first = coin();
		if (pick < 60) begin
			repeat (hold) send_tick(on_first, !on_first, pulse_clear());
			if ($urandom_range(3) == 0) begin
				repeat ($urandom_range(1, 4)) send_tick(1'b1, 1'b1, pulse_clear());
				send_tick(on_first, !on_first, pulse_clear());
			end
			send_tick(1'b0, 1'b0, pulse_clear());
		end else if (pick < 72) begin
			send_tick(1'b1, 1'b1, pulse_clear());
			repeat (hold) send_tick(coin(), 1'b1, pulse_clear());
			send_tick(1'b0, 1'b0, pulse_clear());
		end else begin
			repeat ($urandom_range(1, 8))
				send_tick(coin(), coin(), coin());
		end
		repeat ($urandom_range(0, 2)) send_tick(1'b0, 1'b0, pulse_clear());
	endtask

	task automatic run_gestures(input int count);
		int stop_at;
		stop_at = ticks_sent + count;
		while (ticks_sent < stop_at)
			run_gesture();
	endtask

	// Reset intervals: short presses, simultaneous press, long beating both held
	task automatic test_directed_cases();
		send_tick(1'b0, 1'b0, 1'b0);
		repeat (3) send_tick(1'b1, 1'b0, 1'b0);
		send_tick(1'b0, 1'b0, 1'b0);
		send_tick(1'b0, 1'b0, 1'b1);
		send_tick(1'b1, 1'b1, 1'b0);
		send_tick(1'b0, 1'b0, 1'b0);
		repeat (5) send_tick(1'b1, 1'b0, 1'b0);
		send_tick(1'b1, 1'b1, 1'b0);
		send_tick(1'b1, 1'b1, 1'b0);
		send_tick(1'b0, 1'b1, 1'b0);
		send_tick(1'b0, 1'b0, 1'b0);
	endtask

	// Shortest intervals: repeat every tick, clear while long, unused indexes
	task automatic test_fast_intervals();
		set_intervals(8'd1, 8'd1);
		repeat (4) send_tick(1'b0, 1'b1, 1'b0);
		send_tick(1'b0, 1'b0, 1'b0);
		repeat (3) send_tick(1'b1, 1'b0, 1'b0);
		send_tick(1'b1, 1'b0, 1'b1);
		send_tick(1'b0, 1'b0, 1'b0);
		drain();
		cfg_write(REG_SPARE_2, 8'hA5);
		cfg_write(REG_SPARE_3, 8'h5A);
		cfg_done();
		run_gestures(60);
	endtask

	// Longest first interval into fast repeats, then longest intervals together
	task automatic test_long_intervals();
		set_intervals(8'd255, 8'd1);
		repeat (258) send_tick(1'b1, 1'b0, pulse_clear());
		send_tick(1'b0, 1'b0, 1'b0);
		set_intervals(8'd255, 8'd255);
		run_gestures(30);
	endtask

	// Random intervals, first phase at full rate on both sides
	task automatic test_random_intervals();
		for (int phase = 0; phase < 4; phase++) begin
			set_intervals(8'($urandom_range(2, 10)), 8'($urandom_range(1, 6)));
			tx_gaps_on = (phase != 0);
			rx_stall_on = (phase != 0);
			run_gestures(45);
		end
		tx_gaps_on = 1'b1;
		rx_stall_on = 1'b1;
	endtask

	initial begin
		press_model.state = btnrep_pkg::ST_IDLE;
		press_model.count = '0;
		press_model.flags = '0;
		iv_first = btnrep_pkg::FIRST_INTERVAL_RST;
		iv_repeat = btnrep_pkg::REPEAT_INTERVAL_RST;
		repeat (RESET_TICKS) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_fast_intervals();
		test_long_intervals();
		test_random_intervals();

		drain();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && expected_events.size() == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
